[rtl/pmvf_pkg.sv]
// Shared constants, types and helper functions for the pose median and velocity filter.
package pmvf_pkg;

    // Median window and axis counts.
    localparam int WINDOW_LEN  = 5;
    localparam int SLOT_W      = $clog2(WINDOW_LEN);
    localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
    localparam int MEDIAN_RANK = WINDOW_LEN / 2;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_W      = $clog2(NUM_AXES);

    // Field widths and fixed-point formats.
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int ALPHA_W    = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int ALPHA_FRAC = 16;

    // Shared multiplier operands and product.
    localparam int MUL_A_W = DATA_W + 2;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0]  word_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic [ALPHA_W-1:0]        alpha_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    // Register indexes on the configuration channel.
    localparam cfg_idx_t REG_GAIN_X         = 3'd0;
    localparam cfg_idx_t REG_GAIN_Y         = 3'd1;
    localparam cfg_idx_t REG_GAIN_HEADING   = 3'd2;
    localparam cfg_idx_t REG_OFFSET_X       = 3'd3;
    localparam cfg_idx_t REG_OFFSET_Y       = 3'd4;
    localparam cfg_idx_t REG_OFFSET_HEADING = 3'd5;
    localparam cfg_idx_t REG_SMOOTH_ALPHA   = 3'd6;

    // Register values after reset.
    localparam gain_t  GAIN_X_RST         = 16'sd11693;
    localparam gain_t  GAIN_Y_RST         = 16'sd11441;
    localparam gain_t  GAIN_HEADING_RST   = 16'sd16450;
    localparam word_t  OFFSET_X_RST       = -32'sd51688;
    localparam word_t  OFFSET_Y_RST       = 32'sd36923;
    localparam word_t  OFFSET_HEADING_RST = 32'sd4169;
    localparam alpha_t SMOOTH_ALPHA_RST   = 16'd13107;

    // Half an output LSB, added before the rounding shifts.
    localparam prod_t GAIN_HALF  = prod_t'(1) <<< (GAIN_FRAC - 1);
    localparam prod_t ALPHA_HALF = prod_t'(1) <<< (ALPHA_FRAC - 1);

    // Sign-extends a word to the product width.
    function automatic prod_t widen(input word_t v);
        widen = $signed({{(PROD_W - DATA_W){v[DATA_W-1]}}, v});
    endfunction

    // Sign-extends a word to the multiplier's A operand width.
    function automatic mul_a_t widen_a(input word_t v);
        widen_a = $signed({{(MUL_A_W - DATA_W){v[DATA_W-1]}}, v});
    endfunction

    // Clamps a product-width value to the signed word range.
    function automatic word_t sat_word(input prod_t v);
        logic [PROD_W-DATA_W:0] top;
        top = v[PROD_W-1:DATA_W-1];
        if ((&top) || (~|top))
            sat_word = word_t'(v[DATA_W-1:0]);
        else if (v[PROD_W-1])
            sat_word = $signed({1'b1, {(DATA_W - 1){1'b0}}});
        else
            sat_word = $signed({1'b0, {(DATA_W - 1){1'b1}}});
    endfunction

endpackage

[rtl/pmvf_ifs.sv]
// Channel interfaces of the pose median and velocity filter: samples, results and configuration.
interface pmvf_sample_if;
    logic                  valid;
    logic                  ready;
    pmvf_pkg::word_t       sample_x;
    pmvf_pkg::word_t       sample_y;
    pmvf_pkg::word_t       sample_heading;

    modport source (output valid, output sample_x, output sample_y, output sample_heading,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_heading,
                    output ready);
endinterface

interface pmvf_result_if;
    logic                  valid;
    logic                  ready;
    pmvf_pkg::word_t       filtered_x;
    pmvf_pkg::word_t       filtered_y;
    pmvf_pkg::word_t       filtered_heading;
    pmvf_pkg::word_t       speed_x;
    pmvf_pkg::word_t       speed_y;
    pmvf_pkg::word_t       speed_heading;

    modport source (output valid, output filtered_x, output filtered_y,
                    output filtered_heading, output speed_x, output speed_y,
                    output speed_heading, input ready);
    modport sink   (input valid, input filtered_x, input filtered_y,
                    input filtered_heading, input speed_x, input speed_y,
                    input speed_heading, output ready);
endinterface

interface pmvf_cfg_if;
    logic                  valid;
    logic                  ready;
    pmvf_pkg::cfg_idx_t    index;
    pmvf_pkg::word_t       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pose_median_velocity_filter.sv]
// Top level of the pose median and velocity filter: median, calibration and smoothed velocity.
//
//  Channel   Dir   Beat contents
//  -------   ---   ---------------------------------------------------------------
//  sample    in    sample_x, sample_y, sample_heading (signed Q16.16)
//  result    out   filtered_x/y/heading, speed_x/y/heading (signed Q16.16)
//  cfg       in    index (register number 0..6), data (write value; index 7 is ignored)
//
// For each sample beat, each of the three axes searches its window for the median with a single
// rank comparator row, then passes through MUL_GAIN, CALIB, DIFF, MUL_ALPHA and UPDATE on one
// shared 34 x 17 multiplier and its adders; after the last axis the result beat is offered.
// The sample channel is ready again in the cycle after the result enters the output register,
// so a waiting result does not block the next sample; a finished item waits only if the
// previous result is still held. Reset (rst_n low) clears windows, history and outputs at
// once and loads the calibration defaults. Configuration beats are always taken.
module pose_median_velocity_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    pmvf_sample_if.sink          sample,
    pmvf_result_if.source        result,
    pmvf_cfg_if.sink             cfg
);

    // The sequencer walks the axes one after another; every arithmetic state uses the
    // same multiplier or adder path on the current axis.
    typedef enum logic [2:0] {
        IDLE,
        RANK,
        MUL_GAIN,
        CALIB,
        DIFF,
        MUL_ALPHA,
        UPDATE,
        DONE
    } state_t;

    state_t state_reg;

    logic [pmvf_pkg::AXIS_W-1:0] axis_reg;
    logic [pmvf_pkg::SLOT_W-1:0] rank_reg;
    logic [pmvf_pkg::SLOT_W-1:0] slot_reg;

    // Sliding windows, kept in arrival order, one row per axis.
    pmvf_pkg::word_t win_reg [pmvf_pkg::NUM_AXES][pmvf_pkg::WINDOW_LEN];

    // History carried from one sample to the next.
    pmvf_pkg::word_t prev_reg  [pmvf_pkg::NUM_AXES];
    pmvf_pkg::word_t speed_reg [pmvf_pkg::NUM_AXES];

    // Calibration registers.
    pmvf_pkg::gain_t  gain_reg   [pmvf_pkg::NUM_AXES];
    pmvf_pkg::word_t  offset_reg [pmvf_pkg::NUM_AXES];
    pmvf_pkg::alpha_t alpha_reg;

    // Working registers of the shared datapath.
    pmvf_pkg::word_t  med_reg;
    pmvf_pkg::prod_t  prod_reg;
    pmvf_pkg::word_t  filt_reg;
    pmvf_pkg::mul_a_t diff_reg;

    // Output register, loaded in one go once all axes are done.
    pmvf_pkg::word_t out_filt_reg  [pmvf_pkg::NUM_AXES];
    pmvf_pkg::word_t out_speed_reg [pmvf_pkg::NUM_AXES];
    logic            out_valid_reg;

    // Rank test of one window entry against its whole row: the entry is a median when
    // at most MEDIAN_RANK entries are below it and more than that are at or below it.
    pmvf_pkg::word_t            cand;
    logic [pmvf_pkg::CNT_W-1:0] lt_cnt;
    logic [pmvf_pkg::CNT_W-1:0] le_cnt;
    logic                       is_median;

    always_comb
    begin
        cand   = win_reg[axis_reg][rank_reg];
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < pmvf_pkg::WINDOW_LEN; j++)
        begin
            if (win_reg[axis_reg][j] < cand)
                lt_cnt = lt_cnt + pmvf_pkg::CNT_W'(1);
            if (win_reg[axis_reg][j] <= cand)
                le_cnt = le_cnt + pmvf_pkg::CNT_W'(1);
        end
        is_median = (lt_cnt <= pmvf_pkg::CNT_W'(pmvf_pkg::MEDIAN_RANK))
                 && (le_cnt >  pmvf_pkg::CNT_W'(pmvf_pkg::MEDIAN_RANK));
    end

    // Shared multiplier: median times gain, then velocity error times alpha.
    pmvf_pkg::mul_a_t mul_a;
    pmvf_pkg::mul_b_t mul_b;
    pmvf_pkg::prod_t  product;

    always_comb
    begin
        if (state_reg == MUL_GAIN)
        begin
            mul_a = pmvf_pkg::widen_a(med_reg);
            mul_b = $signed({gain_reg[axis_reg][pmvf_pkg::GAIN_W-1], gain_reg[axis_reg]});
        end
        else
        begin
            mul_a = diff_reg;
            mul_b = $signed({1'b0, alpha_reg});
        end
        product = pmvf_pkg::prod_t'(mul_a) * pmvf_pkg::prod_t'(mul_b);
    end

    // Rounding shifts and the adds that follow them.
    pmvf_pkg::prod_t cal_scaled;
    pmvf_pkg::prod_t cal_sum;
    pmvf_pkg::prod_t step_scaled;
    pmvf_pkg::prod_t speed_sum;
    pmvf_pkg::mul_a_t diff_next;

    always_comb
    begin
        cal_scaled  = (prod_reg + pmvf_pkg::GAIN_HALF) >>> pmvf_pkg::GAIN_FRAC;
        cal_sum     = cal_scaled + pmvf_pkg::widen(offset_reg[axis_reg]);
        step_scaled = (prod_reg + pmvf_pkg::ALPHA_HALF) >>> pmvf_pkg::ALPHA_FRAC;
        speed_sum   = step_scaled + pmvf_pkg::widen(speed_reg[axis_reg]);
        diff_next   = pmvf_pkg::widen_a(filt_reg) - pmvf_pkg::widen_a(prev_reg[axis_reg])
                    - pmvf_pkg::widen_a(speed_reg[axis_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            axis_reg      <= '0;
            rank_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < pmvf_pkg::NUM_AXES; a++)
            begin
                for (int s = 0; s < pmvf_pkg::WINDOW_LEN; s++)
                    win_reg[a][s] <= '0;
                prev_reg[a]      <= '0;
                speed_reg[a]     <= '0;
                out_filt_reg[a]  <= '0;
                out_speed_reg[a] <= '0;
            end
            gain_reg[0]   <= pmvf_pkg::GAIN_X_RST;
            gain_reg[1]   <= pmvf_pkg::GAIN_Y_RST;
            gain_reg[2]   <= pmvf_pkg::GAIN_HEADING_RST;
            offset_reg[0] <= pmvf_pkg::OFFSET_X_RST;
            offset_reg[1] <= pmvf_pkg::OFFSET_Y_RST;
            offset_reg[2] <= pmvf_pkg::OFFSET_HEADING_RST;
            alpha_reg     <= pmvf_pkg::SMOOTH_ALPHA_RST;
            med_reg       <= '0;
            prod_reg      <= '0;
            filt_reg      <= '0;
            diff_reg      <= '0;
        end
        else
        begin
            // Beats land as they come; the user must send writes only while idle, unenforced.
            if (cfg.valid)
            begin
                case (cfg.index)
                    pmvf_pkg::REG_GAIN_X:
                        gain_reg[0] <= pmvf_pkg::gain_t'(cfg.data[pmvf_pkg::GAIN_W-1:0]);
                    pmvf_pkg::REG_GAIN_Y:
                        gain_reg[1] <= pmvf_pkg::gain_t'(cfg.data[pmvf_pkg::GAIN_W-1:0]);
                    pmvf_pkg::REG_GAIN_HEADING:
                        gain_reg[2] <= pmvf_pkg::gain_t'(cfg.data[pmvf_pkg::GAIN_W-1:0]);
                    pmvf_pkg::REG_OFFSET_X:       offset_reg[0] <= cfg.data;
                    pmvf_pkg::REG_OFFSET_Y:       offset_reg[1] <= cfg.data;
                    pmvf_pkg::REG_OFFSET_HEADING: offset_reg[2] <= cfg.data;
                    pmvf_pkg::REG_SMOOTH_ALPHA:
                        alpha_reg <= cfg.data[pmvf_pkg::ALPHA_W-1:0];
                    default: ;
                endcase
            end

            // The output register fills from a finished item once it is free or being
            // taken, and otherwise empties when its beat is taken.
            if ((state_reg == DONE) && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    // The new sample replaces the oldest entry of each window.
                    if (sample.valid)
                    begin
                        win_reg[0][slot_reg] <= sample.sample_x;
                        win_reg[1][slot_reg] <= sample.sample_y;
                        win_reg[2][slot_reg] <= sample.sample_heading;
                        if (slot_reg == pmvf_pkg::SLOT_W'(pmvf_pkg::WINDOW_LEN - 1))
                            slot_reg <= '0;
                        else
                            slot_reg <= slot_reg + pmvf_pkg::SLOT_W'(1);
                        axis_reg  <= '0;
                        rank_reg  <= '0;
                        state_reg <= RANK;
                    end
                end

                RANK:
                begin
                    // One window entry is tested per cycle; some entry always qualifies.
                    if (is_median)
                    begin
                        med_reg   <= cand;
                        state_reg <= MUL_GAIN;
                    end
                    else
                    begin
                        rank_reg <= rank_reg + pmvf_pkg::SLOT_W'(1);
                    end
                end

                MUL_GAIN:
                begin
                    prod_reg  <= product;
                    state_reg <= CALIB;
                end

                CALIB:
                begin
                    filt_reg  <= pmvf_pkg::sat_word(cal_sum);
                    state_reg <= DIFF;
                end

                DIFF:
                begin
                    // Raw velocity minus the smoothed one, exact in 34 bits.
                    diff_reg  <= diff_next;
                    state_reg <= MUL_ALPHA;
                end

                MUL_ALPHA:
                begin
                    prod_reg  <= product;
                    state_reg <= UPDATE;
                end

                UPDATE:
                begin
                    prev_reg[axis_reg]  <= filt_reg;
                    speed_reg[axis_reg] <= pmvf_pkg::sat_word(speed_sum);
                    if (axis_reg == pmvf_pkg::AXIS_W'(pmvf_pkg::NUM_AXES - 1))
                    begin
                        state_reg <= DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + pmvf_pkg::AXIS_W'(1);
                        rank_reg  <= '0;
                        state_reg <= RANK;
                    end
                end

                DONE:
                begin
                    // Hand the finished item to the output register once it is free or being taken.
                    if (!out_valid_reg || result.ready)
                    begin
                        out_filt_reg  <= prev_reg;
                        out_speed_reg <= speed_reg;
                        state_reg     <= IDLE;
                    end
                end

                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    assign sample.ready = (state_reg == IDLE);
    assign cfg.ready    = 1'b1;

    assign result.valid            = out_valid_reg;
    assign result.filtered_x       = out_filt_reg[0];
    assign result.filtered_y       = out_filt_reg[1];
    assign result.filtered_heading = out_filt_reg[2];
    assign result.speed_x          = out_speed_reg[0];
    assign result.speed_y          = out_speed_reg[1];
    assign result.speed_heading    = out_speed_reg[2];

endmodule

[rtl/pmvf_checker.sv]
// Port-level assertions for the pose median and velocity filter, with the bind that attaches them.
module pmvf_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [191:0] out_payload
);

    // A sample keeps the block busy, so the sample channel drops right after a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sample channel still ready after an accepted beat");

    // A result must pass through every state first, so none can appear in the cycle after a sample beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared directly after a sample beat");

    // The block is busy while working, so the sample channel stays low while the first axis is worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 !in_ready)
        else $error("sample channel ready too soon after a beat");

    // A stalled result beat holds its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))
        else $error("stalled result beat changed");

endmodule

bind pose_median_velocity_filter pmvf_checker u_pmvf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload ({result.filtered_x, result.filtered_y, result.filtered_heading,
                   result.speed_x, result.speed_y, result.speed_heading})
);

[tb/pmvf_result_check.sv]
`timescale 1ns / 100ps
// Result checker for the pose filter: predicts each result beat and compares it field by field.
module pmvf_result_check (
    input  logic   clk,
    input  logic   rst_n,
    pmvf_sample_if sample,
    pmvf_result_if result,
    pmvf_cfg_if    cfg,
    output int     errors,
    output int     outstanding
);

    localparam pmvf_pkg::word_t WORD_MAX    = 32'sh7FFF_FFFF;
    localparam pmvf_pkg::word_t WORD_MIN    = 32'sh8000_0000;
    localparam int              PRINT_LIMIT = 50;

    typedef struct {
        pmvf_pkg::word_t filt_x;
        pmvf_pkg::word_t filt_y;
        pmvf_pkg::word_t filt_heading;
        pmvf_pkg::word_t speed_x;
        pmvf_pkg::word_t speed_y;
        pmvf_pkg::word_t speed_heading;
    } pose_result_t;

    // Calibration settings as the block should hold them.
    pmvf_pkg::gain_t  cal_gain   [pmvf_pkg::NUM_AXES];
    pmvf_pkg::word_t  cal_offset [pmvf_pkg::NUM_AXES];
    pmvf_pkg::alpha_t vel_alpha;

    // Sample history and filter memory per axis.
    pmvf_pkg::word_t  recent     [pmvf_pkg::NUM_AXES][pmvf_pkg::WINDOW_LEN];
    int               write_pos;
    pmvf_pkg::word_t  prev_cal   [pmvf_pkg::NUM_AXES];
    pmvf_pkg::word_t  vel_avg    [pmvf_pkg::NUM_AXES];

    pose_result_t expected_poses [$];
    int           mismatch_count = 0;
    int           pending_count  = 0;

    assign errors      = mismatch_count;
    assign outstanding = pending_count;

    task automatic report_mismatch(input string what, input pmvf_pkg::word_t got,
                                   input pmvf_pkg::word_t want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic check_field(input string what, input pmvf_pkg::word_t got,
                               input pmvf_pkg::word_t want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic pmvf_pkg::word_t clamp_word(input longint v);
        if (v > longint'(WORD_MAX))
            return WORD_MAX;
        if (v < longint'(WORD_MIN))
            return WORD_MIN;
        return pmvf_pkg::word_t'(v);
    endfunction

    // Middle element of a sorted copy; the history itself keeps arrival order.
    function automatic pmvf_pkg::word_t window_median(input int axis);
        pmvf_pkg::word_t sorted [pmvf_pkg::WINDOW_LEN];
        pmvf_pkg::word_t v;
        int              j;
        for (int i = 0; i < pmvf_pkg::WINDOW_LEN; i++)
        begin
            v = recent[axis][i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[pmvf_pkg::MEDIAN_RANK];
    endfunction

    task automatic filter_pose(input pmvf_pkg::word_t sx, input pmvf_pkg::word_t sy,
                               input pmvf_pkg::word_t sh, output pose_result_t r);
        pmvf_pkg::word_t filt [pmvf_pkg::NUM_AXES];
        pmvf_pkg::word_t spd  [pmvf_pkg::NUM_AXES];
        longint          scaled;
        longint          raw;
        longint          delta;
        recent[0][write_pos] = sx;
        recent[1][write_pos] = sy;
        recent[2][write_pos] = sh;
        write_pos = (write_pos == pmvf_pkg::WINDOW_LEN - 1) ? 0 : write_pos + 1;
        for (int a = 0; a < pmvf_pkg::NUM_AXES; a++)
        begin
            scaled = (longint'(window_median(a)) * longint'(cal_gain[a])
                      + (longint'(1) <<< (pmvf_pkg::GAIN_FRAC - 1))) >>> pmvf_pkg::GAIN_FRAC;
            filt[a] = clamp_word(scaled + longint'(cal_offset[a]));
            raw = longint'(filt[a]) - longint'(prev_cal[a]);
            delta = ((raw - longint'(vel_avg[a])) * longint'(vel_alpha)
                     + (longint'(1) <<< (pmvf_pkg::ALPHA_FRAC - 1))) >>> pmvf_pkg::ALPHA_FRAC;
            spd[a] = clamp_word(longint'(vel_avg[a]) + delta);
            prev_cal[a] = filt[a];
            vel_avg[a]  = spd[a];
        end
        r.filt_x        = filt[0];
        r.filt_y        = filt[1];
        r.filt_heading  = filt[2];
        r.speed_x       = spd[0];
        r.speed_y       = spd[1];
        r.speed_heading = spd[2];
    endtask

    task automatic clear_filter_state();
        cal_gain[0]   = pmvf_pkg::GAIN_X_RST;
        cal_gain[1]   = pmvf_pkg::GAIN_Y_RST;
        cal_gain[2]   = pmvf_pkg::GAIN_HEADING_RST;
        cal_offset[0] = pmvf_pkg::OFFSET_X_RST;
        cal_offset[1] = pmvf_pkg::OFFSET_Y_RST;
        cal_offset[2] = pmvf_pkg::OFFSET_HEADING_RST;
        vel_alpha     = pmvf_pkg::SMOOTH_ALPHA_RST;
        for (int a = 0; a < pmvf_pkg::NUM_AXES; a++)
        begin
            for (int i = 0; i < pmvf_pkg::WINDOW_LEN; i++)
                recent[a][i] = '0;
            prev_cal[a] = '0;
            vel_avg[a]  = '0;
        end
        write_pos = 0;
        expected_poses.delete();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_result_t pose;
        if (!rst_n)
        begin
            clear_filter_state();
        end
        else
        begin
            // Results are matched before new samples are queued; no result can belong
            // to a sample taken on the same edge.
            if (result.valid && result.ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    report_mismatch("unexpected result beat", result.filtered_x, '0);
                end
                else
                begin
                    pose = expected_poses.pop_front();
                    check_field("filtered_x", result.filtered_x, pose.filt_x);
                    check_field("filtered_y", result.filtered_y, pose.filt_y);
                    check_field("filtered_heading", result.filtered_heading, pose.filt_heading);
                    check_field("speed_x", result.speed_x, pose.speed_x);
                    check_field("speed_y", result.speed_y, pose.speed_y);
                    check_field("speed_heading", result.speed_heading, pose.speed_heading);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    pmvf_pkg::REG_GAIN_X:
                        cal_gain[0] = pmvf_pkg::gain_t'(cfg.data[pmvf_pkg::GAIN_W-1:0]);
                    pmvf_pkg::REG_GAIN_Y:
                        cal_gain[1] = pmvf_pkg::gain_t'(cfg.data[pmvf_pkg::GAIN_W-1:0]);
                    pmvf_pkg::REG_GAIN_HEADING:
                        cal_gain[2] = pmvf_pkg::gain_t'(cfg.data[pmvf_pkg::GAIN_W-1:0]);
                    pmvf_pkg::REG_OFFSET_X:       cal_offset[0] = cfg.data;
                    pmvf_pkg::REG_OFFSET_Y:       cal_offset[1] = cfg.data;
                    pmvf_pkg::REG_OFFSET_HEADING: cal_offset[2] = cfg.data;
                    pmvf_pkg::REG_SMOOTH_ALPHA:
                        vel_alpha = cfg.data[pmvf_pkg::ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
            begin
                filter_pose(sample.sample_x, sample.sample_y, sample.sample_heading, pose);
                expected_poses.push_back(pose);
            end
        end
        pending_count <= expected_poses.size();
    end

endmodule

[tb/pose_median_velocity_filter_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the pose median and velocity filter: clock, reset, stimulus and verdict.
module pose_median_velocity_filter_tb;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 5;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 250;
    // This margin covers the slowest item after the output has settled.
    localparam int DRAIN_CYCLES    = 40;
    // Cycles without any beat before the run is declared hung. A correct run never gets
    // close: even the slowest item and heavy random stalls end quickly.
    localparam int QUIET_LIMIT     = 2000;

    // Register index that the block must ignore.
    localparam pmvf_pkg::cfg_idx_t REG_UNUSED = 3'd7;

    localparam pmvf_pkg::word_t  WORD_TOP    = 32'sh7FFF_FFFF;
    localparam pmvf_pkg::word_t  WORD_BOTTOM = 32'sh8000_0000;
    localparam pmvf_pkg::gain_t  GAIN_TOP    = 16'sh7FFF;
    localparam pmvf_pkg::gain_t  GAIN_BOTTOM = 16'sh8000;
    localparam pmvf_pkg::gain_t  GAIN_UNITY  = 16'sh4000;
    localparam pmvf_pkg::alpha_t ALPHA_FULL  = 16'hFFFF;

    logic   clk = 1'b0;
    logic   rst_n;
    int     idle_pct;
    int     stall_pct;
    int     errors;
    int     outstanding;
    int     quiet_cycles;
    longint track [pmvf_pkg::NUM_AXES];

    pmvf_sample_if sample_ch();
    pmvf_result_if result_ch();
    pmvf_cfg_if    cfg_ch();

    pose_median_velocity_filter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // The checker sees every beat on all three channels, predicts each result and
    // hands back its mismatch count and the number of results still owed.
    pmvf_result_check u_pose_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The receiver stalls at random; stall_pct follows the current idling phase.
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Lowers the sample valid and waits until every result owed has been taken. The
    // first edge is always waited so that a beat taken on this edge is counted.
    task automatic wait_until_drained();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // One register write. Valid is dropped for a cycle afterwards so that the next
    // write never lowers and raises it within the same time step.
    task automatic write_reg(input pmvf_pkg::cfg_idx_t idx, input pmvf_pkg::word_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_calibration(input pmvf_pkg::gain_t gx, input pmvf_pkg::gain_t gy,
                                     input pmvf_pkg::gain_t gh, input pmvf_pkg::word_t ox,
                                     input pmvf_pkg::word_t oy, input pmvf_pkg::word_t oh,
                                     input pmvf_pkg::alpha_t al);
        write_reg(pmvf_pkg::REG_GAIN_X, pmvf_pkg::word_t'(gx));
        write_reg(pmvf_pkg::REG_GAIN_Y, pmvf_pkg::word_t'(gy));
        write_reg(pmvf_pkg::REG_GAIN_HEADING, pmvf_pkg::word_t'(gh));
        write_reg(pmvf_pkg::REG_OFFSET_X, ox);
        write_reg(pmvf_pkg::REG_OFFSET_Y, oy);
        write_reg(pmvf_pkg::REG_OFFSET_HEADING, oh);
        write_reg(pmvf_pkg::REG_SMOOTH_ALPHA, pmvf_pkg::word_t'({16'h0, al}));
    endtask

    // Presents one pose beat after a random gap and holds it until it is taken. Valid
    // is left high on return, so back-to-back beats keep it high without a glitch.
    task automatic send_pose(input pmvf_pkg::word_t x, input pmvf_pkg::word_t y,
                             input pmvf_pkg::word_t h);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.sample_x       <= x;
        sample_ch.sample_y       <= y;
        sample_ch.sample_heading <= h;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    function automatic pmvf_pkg::gain_t pick_gain();
        case ($urandom_range(4))
            0:       return GAIN_TOP;
            1:       return GAIN_BOTTOM;
            2:       return GAIN_UNITY;
            default: return pmvf_pkg::gain_t'($urandom);
        endcase
    endfunction

    function automatic pmvf_pkg::word_t pick_offset();
        case ($urandom_range(4))
            0:       return WORD_TOP;
            1:       return WORD_BOTTOM;
            2:       return pmvf_pkg::word_t'(longint'($urandom_range(1 << 21)) - (1 << 20));
            default: return pmvf_pkg::word_t'($urandom);
        endcase
    endfunction

    function automatic pmvf_pkg::alpha_t pick_alpha();
        case ($urandom_range(3))
            0:       return '0;
            1:       return ALPHA_FULL;
            default: return pmvf_pkg::alpha_t'($urandom);
        endcase
    endfunction

    // Most coordinates follow a slow random walk, as a real pose track would, so the
    // medians and speeds stay meaningful. The rest are single-sample spikes that the
    // median should reject, jumps to a new random place, and the range extremes.
    function automatic pmvf_pkg::word_t next_coord(input int axis);
        int unsigned     pick;
        pmvf_pkg::word_t v;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            track[axis] = track[axis] + longint'($urandom_range(1 << 19)) - (1 << 18);
            v = pmvf_pkg::word_t'(track[axis]);
        end
        else if (pick < 75)
        begin
            v = pmvf_pkg::word_t'($urandom);
        end
        else if (pick < 90)
        begin
            v = pmvf_pkg::word_t'($urandom);
            track[axis] = longint'(v);
        end
        else
        begin
            case ($urandom_range(3))
                0:       v = WORD_TOP;
                1:       v = WORD_BOTTOM;
                2:       v = '0;
                default: v = -32'sd1;
            endcase
        end
        return v;
    endfunction

    // Watchdog: ends the run if no beat moves on any channel for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        // Every input of the block is known from time zero.
        rst_n                    = 1'b0;
        sample_ch.valid          = 1'b0;
        sample_ch.sample_x       = '0;
        sample_ch.sample_y       = '0;
        sample_ch.sample_heading = '0;
        result_ch.ready          = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = pmvf_pkg::REG_GAIN_X;
        cfg_ch.data              = '0;
        idle_pct                 = 0;
        stall_pct                = 0;
        for (int a = 0; a < pmvf_pkg::NUM_AXES; a++)
            track[a] = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset calibration. The first beats meet windows that still hold
        // the zeros from reset, and the first speed is taken against a zero history.
        send_pose('0, '0, '0);
        send_pose(WORD_TOP, WORD_BOTTOM, -32'sd1);
        send_pose(WORD_TOP, WORD_BOTTOM, 32'sd1);
        send_pose(WORD_BOTTOM, WORD_TOP, WORD_TOP);
        send_pose(WORD_BOTTOM, WORD_TOP, WORD_BOTTOM);
        send_pose(WORD_TOP, WORD_BOTTOM, '0);
        send_pose(32'sd1, -32'sd1, 32'sh0001_0000);
        send_pose(-32'sd65536, 32'sd65536, 32'sh7FFF_0000);
        send_pose(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);

        // Largest x and y gains and offsets, full-weight smoothing: calibration and speed
        // both saturate, on both sides. The write to the unused index must change nothing.
        wait_until_drained();
        write_calibration(GAIN_TOP, GAIN_BOTTOM, '0, WORD_TOP, WORD_BOTTOM, '0, ALPHA_FULL);
        write_reg(REG_UNUSED, 32'sh1234_5678);
        repeat (3) send_pose(WORD_TOP, WORD_TOP, WORD_TOP);
        repeat (3) send_pose(WORD_BOTTOM, WORD_BOTTOM, WORD_BOTTOM);

        // The opposite extremes, with zero smoothing weight so the speeds freeze.
        wait_until_drained();
        write_calibration(GAIN_BOTTOM, GAIN_TOP, -16'sd1, WORD_BOTTOM, WORD_TOP, -32'sd1, '0);
        write_reg(REG_UNUSED, 32'shFFFF_FFFF);
        send_pose(WORD_TOP, WORD_BOTTOM, WORD_TOP);
        send_pose(WORD_BOTTOM, WORD_TOP, WORD_BOTTOM);
        send_pose(WORD_TOP, WORD_BOTTOM, '0);
        send_pose(WORD_BOTTOM, WORD_TOP, -32'sd1);
        send_pose(WORD_TOP, WORD_TOP, WORD_BOTTOM);

        // Random part. Each phase starts from an idle block with its own calibration;
        // the idling mode cycles through none, sender gaps, receiver stalls and both.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_drained();
            if (p == 0)
                write_calibration(pmvf_pkg::GAIN_X_RST, pmvf_pkg::GAIN_Y_RST,
                                  pmvf_pkg::GAIN_HEADING_RST, pmvf_pkg::OFFSET_X_RST,
                                  pmvf_pkg::OFFSET_Y_RST, pmvf_pkg::OFFSET_HEADING_RST,
                                  pmvf_pkg::SMOOTH_ALPHA_RST);
            else
                write_calibration(pick_gain(), pick_gain(), pick_gain(), pick_offset(),
                                  pick_offset(), pick_offset(), pick_alpha());
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 74;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 74;
                end
                default:
                begin
                    idle_pct = 9;
                    stall_pct <= 9;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Halfway through the first stalling phase the sender holds off until the
                // results held back by the receiver have all been drained.
                if (p == 2 && i == ITEMS_PER_PHASE / 2)
                    wait_until_drained();
                send_pose(next_coord(0), next_coord(1), next_coord(2));
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
